>>> rtl/core/mcp_pkg.sv
package mcp_pkg;

  localparam int unsigned AngleW   = 16;
  localparam int unsigned AxisW    = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ProductW = AngleW + 3;

  localparam logic [AngleW-1:0] MaxAngle = 16'd36000;

  localparam logic [AxisW-1:0] AxisX = 2'd0;
  localparam logic [AxisW-1:0] AxisY = 2'd1;
  localparam logic [AxisW-1:0] AxisZ = 2'd2;

  localparam logic [7:0] ChSpace = 8'h20;

  // Progress value once the whole word "finished" has been seen
  localparam logic [3:0] FinDone = 4'd8;

  typedef enum logic [StatusW-1:0] {
    StRunMove   = 3'd0,
    StOnline    = 3'd1,
    StUndefined = 3'd2,
    StRange     = 3'd3,
    StFinished  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    GoSeekG    = 3'd0,
    GoSeenG    = 3'd1,
    GoSkipAxis = 3'd2,
    GoSkipNum  = 3'd3,
    GoDigits   = 3'd4,
    GoDone     = 3'd5,
    GoBadAxis  = 3'd6,
    GoTooLarge = 3'd7
  } go_phase_e;

  typedef struct packed {
    go_phase_e         phase;
    logic [AxisW-1:0]  axis;
    logic [AngleW-1:0] angle;
  } go_info_t;

  // Lower-case only A..Z; every other byte passes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] fin_letter(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h66;  // f
      3'd1: r = 8'h69;  // i
      3'd2: r = 8'h6E;  // n
      3'd3: r = 8'h69;  // i
      3'd4: r = 8'h73;  // s
      3'd5: r = 8'h68;  // h
      3'd6: r = 8'h65;  // e
      default: r = 8'h64;  // d
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/motion_command_parser_unit.sv
// Channel  | Direction | tdata (low bit up)                      | tlast
// s_axis   | in        | [7:0] ch                                | end_of_text
// m_axis   | out       | [2:0] status, [4:3] axis, [20:5] angle  | -
//
// One character word is taken every cycle; matcher state updates at the accept edge.
// An end word produces its status word in the cycle after it is accepted, from the output register.
// The input holds off while a result waits in that register and is not drained in the
// same cycle, so a stalled output stalls every input word, not only the next end word.
// Reset clears all matchers and the output valid flag.
module motion_command_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [2:0] status, [4:3] axis, [20:5] angle
);
  import mcp_pkg::*;

  typedef enum logic [2:0] {
    ImSeekI  = 3'd0,
    ImSeenI  = 3'd1,
    ImSkip   = 3'd2,
    ImSeenO  = 3'd3,
    ImOn     = 3'd4,
    ImFailed = 3'd5
  } im_phase_e;

  logic       accept, step, clear;
  logic [7:0] ch;
  go_info_t   go_info;

  im_phase_e  im_q, im_d;
  logic [3:0] fin_q, fin_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [AxisW-1:0]  axis_q, axis_d;
  logic [AngleW-1:0] angle_q, angle_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign step   = accept && !s_axis_tlast_i;
  assign clear  = accept && s_axis_tlast_i;
  assign ch     = fold_case(s_axis_tdata_i);

  mcp_go_track u_go_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (ch),
    .step_i  (step),
    .clear_i (clear),
    .info_o  (go_info)
  );

  always_comb begin
    im_d = im_q;
    case (im_q)
      ImSeekI: begin
        if (ch == 8'h69) im_d = ImSeenI;
      end
      ImSeenI: begin
        if (ch == 8'h6D) im_d = ImSkip;
        else if (ch != 8'h69) im_d = ImSeekI;
      end
      ImSkip: begin
        if (ch != ChSpace) im_d = (ch == 8'h6F) ? ImSeenO : ImFailed;
      end
      ImSeenO: begin
        im_d = (ch == 8'h6E) ? ImOn : ImFailed;
      end
      default: begin
        im_d = im_q;
      end
    endcase
  end

  always_comb begin
    fin_d = fin_q;
    if (fin_q < FinDone) begin
      if (ch == fin_letter(fin_q[2:0])) fin_d = fin_q + 4'd1;
      else fin_d = (ch == fin_letter(3'd0)) ? 4'd1 : 4'd0;
    end
  end

  // GO outcome wins, then ON, then finished
  always_comb begin
    status_d = StUndefined;
    axis_d   = '0;
    angle_d  = '0;
    case (go_info.phase)
      GoSkipNum, GoDigits, GoDone: begin
        status_d = StRunMove;
        axis_d   = go_info.axis;
        angle_d  = go_info.angle;
      end
      GoTooLarge: status_d = StRange;
      GoSkipAxis, GoBadAxis: status_d = StUndefined;
      default: begin
        if (im_q == ImOn) status_d = StOnline;
        else if (fin_q >= FinDone) status_d = StFinished;
        else status_d = StUndefined;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      im_q  <= ImSeekI;
      fin_q <= '0;
    end else if (clear) begin
      im_q  <= ImSeekI;
      fin_q <= '0;
    end else if (step) begin
      im_q  <= im_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload holds until the next end word is taken
  always_ff @(posedge clk_i) begin
    if (clear) begin
      status_q <= status_d;
      axis_q   <= axis_d;
      angle_q  <= angle_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, angle_q, axis_q, status_q};

  a_end_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("end word accepted without a result");

  a_run_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status_q == StRunMove |-> angle_q <= MaxAngle && axis_q != 2'd3)
    else $error("run move result out of range");

  a_other_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status_q != StRunMove |-> axis_q == '0 && angle_q == '0)
    else $error("axis or angle set on non-move status");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result is stalled");

endmodule

>>> rtl/core/mcp_go_track.sv
module mcp_go_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_i,
  input  logic              step_i,
  input  logic              clear_i,
  output mcp_pkg::go_info_t info_o
);
  import mcp_pkg::*;

  go_phase_e         phase_q, phase_d;
  logic [AxisW-1:0]  axis_q, axis_d;
  logic [AngleW-1:0] angle_q, angle_d;
  logic [ProductW-1:0] product;

  // acc * 10 + digit as two shifts and two adds
  assign product = {angle_q, 3'b000} + {2'b00, angle_q, 1'b0}
                 + {{(ProductW-4){1'b0}}, char_i[3:0]};

  always_comb begin
    phase_d = phase_q;
    axis_d  = axis_q;
    angle_d = angle_q;
    case (phase_q)
      GoSeekG: begin
        if (char_i == 8'h67) phase_d = GoSeenG;
      end
      GoSeenG: begin
        if (char_i == 8'h6F) phase_d = GoSkipAxis;
        else if (char_i != 8'h67) phase_d = GoSeekG;
      end
      GoSkipAxis: begin
        if (char_i == 8'h78) begin
          axis_d = AxisX; phase_d = GoSkipNum;
        end else if (char_i == 8'h79) begin
          axis_d = AxisY; phase_d = GoSkipNum;
        end else if (char_i == 8'h7A) begin
          axis_d = AxisZ; phase_d = GoSkipNum;
        end else if (char_i != ChSpace) begin
          phase_d = GoBadAxis;
        end
      end
      GoSkipNum, GoDigits: begin
        if (phase_q == GoSkipNum && char_i == ChSpace) begin
          phase_d = phase_q;
        end else if (char_i inside {[8'h30:8'h39]}) begin
          if (product > {3'b000, MaxAngle}) begin
            phase_d = GoTooLarge;
          end else begin
            angle_d = product[AngleW-1:0];
            phase_d = GoDigits;
          end
        end else begin
          phase_d = GoDone;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= GoSeekG;
      axis_q  <= AxisX;
      angle_q <= '0;
    end else if (clear_i) begin
      phase_q <= GoSeekG;
      axis_q  <= AxisX;
      angle_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      axis_q  <= axis_d;
      angle_q <= angle_d;
    end
  end

  assign info_o.phase = phase_q;
  assign info_o.axis  = axis_q;
  assign info_o.angle = angle_q;

endmodule

>>> tb/sv/motion_command_parser_unit_tb.sv
`timescale 1ns / 1ps

module motion_command_parser_unit_tb;
  import mcp_pkg::*;

  localparam int unsigned RandomItems = 1600;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAtFirst = 450;
  localparam int unsigned HoldAtNext  = 1150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 10;

  localparam logic [63:0] FinWord   = "finished";
  localparam string       NoisePool = "gGoOiImMnNfFxyzXYZ 0123456789sShHeEdD";

  // IM matcher phases
  localparam logic [2:0] ImSeekI = 3'd0;
  localparam logic [2:0] ImSeenI = 3'd1;
  localparam logic [2:0] ImSkip  = 3'd2;
  localparam logic [2:0] ImSeenO = 3'd3;
  localparam logic [2:0] ImOn    = 3'd4;
  localparam logic [2:0] ImFail  = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_word_t;

  typedef struct packed {
    status_e           status;
    logic [AxisW-1:0]  axis;
    logic [AngleW-1:0] angle;
  } cmd_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  motion_command_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  char_word_t  char_q[$];
  cmd_status_t status_q[$];

  // Parser image
  go_phase_e         go_ph = GoSeekG;
  logic [AxisW-1:0]  axis_seen = AxisX;
  logic [AngleW-1:0] angle_sum = '0;
  logic [2:0]        im_ph = ImSeekI;
  logic [3:0]        fin_cnt = '0;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_wait = 0;
  int unsigned tx_mode_left = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_mode_left = 0;
  bit          rx_calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  char_word_t  next_word;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  task automatic put_ch(input logic [7:0] c);
    char_word_t w;
    w.ch  = c;
    w.eot = 1'b0;
    char_q.push_back(w);
    n_queued++;
  endtask

  task automatic put_text(input string s, input bit mix_case);
    for (int i = 0; i < s.len(); i++) begin
      put_ch(mix_case ? rand_case(s[i]) : s[i]);
    end
  endtask

  task automatic put_end();
    char_word_t w;
    w.ch  = 8'($urandom_range(0, 255));
    w.eot = 1'b1;
    char_q.push_back(w);
    n_queued++;
  endtask

  task automatic put_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) put_ch(8'($urandom_range(0, 255)));
      else put_ch(NoisePool[$urandom_range(0, NoisePool.len() - 1)]);
    end
  endtask

  task automatic put_spaces();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 1;
    for (int unsigned i = 0; i < n; i++) put_ch(ChSpace);
  endtask

  function automatic string angle_text();
    case ($urandom_range(0, 9))
      0: return "";
      1: return "36000";
      2: return "36001";
      3: return $sformatf("%0d", $urandom_range(0, 40000));
      4: return $sformatf("%0d", $urandom_range(0, 99999));
      5: return $sformatf("00%0d", $urandom_range(0, 999));
      6: return $sformatf("%0d", $urandom_range(0, 9));
      default: return $sformatf("%0d", $urandom_range(0, 36000));
    endcase
  endfunction

  task automatic put_go();
    string axes;
    axes = "xyz";
    if ($urandom_range(0, 7) == 0) put_text("g", 1'b1);
    put_text("go", 1'b1);
    put_spaces();
    if ($urandom_range(0, 9) != 0) put_ch(rand_case(axes[$urandom_range(0, 2)]));
    else put_noise(1);
    put_spaces();
    put_text(angle_text(), 1'b0);
    if ($urandom_range(0, 2) == 0) put_noise($urandom_range(1, 5));
  endtask

  task automatic put_im();
    if ($urandom_range(0, 7) == 0) put_text("i", 1'b1);
    put_text("im", 1'b1);
    put_spaces();
    case ($urandom_range(0, 7))
      6: begin
        put_text("o", 1'b1);
        put_noise(1);
      end
      7: put_noise(2);
      default: put_text("on", 1'b1);
    endcase
    if ($urandom_range(0, 2) == 0) put_noise($urandom_range(1, 4));
  endtask

  task automatic put_fin();
    string w;
    w = "finished";
    if ($urandom_range(0, 1) == 0) put_noise($urandom_range(1, 3));
    if ($urandom_range(0, 4) == 0) put_text(w.substr(0, $urandom_range(0, 6)), 1'b1);
    else put_text(w, 1'b1);
    if ($urandom_range(0, 1) == 0) put_noise($urandom_range(1, 3));
  endtask

  task automatic add_random_command();
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 4));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_go();
      4, 5: put_im();
      6, 7: put_fin();
      8: begin
        // stack several commands; only the first of each kind counts
        if ($urandom_range(0, 1) == 0) put_fin();
        put_im();
        if ($urandom_range(0, 1) == 0) put_go();
        if ($urandom_range(0, 1) == 0) put_im();
      end
      default: put_noise($urandom_range(0, 12));
    endcase
    put_end();
  endtask

  task automatic add_directed(input string s);
    put_text(s, 1'b0);
    put_end();
  endtask

  // Advance the parser image by one accepted word
  task automatic take_word(input logic [7:0] raw, input logic eot);
    logic [7:0]  c;
    logic [19:0] v;
    cmd_status_t r;
    c = raw;
    if (raw >= "A" && raw <= "Z") c = raw + 8'd32;
    if (eot) begin
      r.status = StUndefined;
      r.axis   = AxisX;
      r.angle  = '0;
      if (go_ph == GoSkipNum || go_ph == GoDigits || go_ph == GoDone) begin
        r.status = StRunMove;
        r.axis   = axis_seen;
        r.angle  = angle_sum;
      end else if (go_ph == GoTooLarge) begin
        r.status = StRange;
      end else if (go_ph == GoSkipAxis || go_ph == GoBadAxis) begin
        r.status = StUndefined;
      end else if (im_ph == ImOn) begin
        r.status = StOnline;
      end else if (fin_cnt >= FinDone) begin
        r.status = StFinished;
      end
      status_q.push_back(r);
      go_ph     = GoSeekG;
      axis_seen = AxisX;
      angle_sum = '0;
      im_ph     = ImSeekI;
      fin_cnt   = '0;
      return;
    end

    case (go_ph)
      GoSeekG: if (c == "g") go_ph = GoSeenG;
      GoSeenG: begin
        if (c == "o") go_ph = GoSkipAxis;
        else if (c != "g") go_ph = GoSeekG;
      end
      GoSkipAxis: begin
        if (c != ChSpace) begin
          go_ph = GoSkipNum;
          case (c)
            "x": axis_seen = AxisX;
            "y": axis_seen = AxisY;
            "z": axis_seen = AxisZ;
            default: go_ph = GoBadAxis;
          endcase
        end
      end
      GoSkipNum, GoDigits: begin
        if (!(go_ph == GoSkipNum && c == ChSpace)) begin
          if (c >= "0" && c <= "9") begin
            v = {4'd0, angle_sum} * 20'd10 + {12'd0, c - 8'h30};
            if (v > {4'd0, MaxAngle}) begin
              go_ph = GoTooLarge;
            end else begin
              angle_sum = v[AngleW-1:0];
              go_ph     = GoDigits;
            end
          end else begin
            go_ph = GoDone;
          end
        end
      end
      default: ;
    endcase

    case (im_ph)
      ImSeekI: if (c == "i") im_ph = ImSeenI;
      ImSeenI: begin
        if (c == "m") im_ph = ImSkip;
        else if (c != "i") im_ph = ImSeekI;
      end
      ImSkip: if (c != ChSpace) im_ph = (c == "o") ? ImSeenO : ImFail;
      ImSeenO: im_ph = (c == "n") ? ImOn : ImFail;
      default: ;
    endcase

    if (fin_cnt < FinDone) begin
      if (c == FinWord[63 - 8 * fin_cnt[2:0] -: 8]) fin_cnt = fin_cnt + 4'd1;
      else fin_cnt = (c == "f") ? 4'd1 : 4'd0;
    end
  endtask

  // Sender: one word per handshake, random gaps between words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'd0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_word(s_tdata, s_tlast);
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0 || char_q.size() == 0) begin
          s_tvalid <= 1'b0;
          if (tx_wait != 0) tx_wait <= tx_wait - 1;
        end else begin
          next_word = char_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_word.ch;
          s_tlast  <= next_word.eot;
          if (tx_mode_left == 0) begin
            tx_calm      <= ($urandom_range(0, 2) == 0);
            tx_mode_left <= $urandom_range(20, 150);
          end else begin
            tx_mode_left <= tx_mode_left - 1;
          end
          tx_wait <= tx_calm ? 0 : pick_gap();
        end
      end
    end
  end

  // Long receiver hold-off so the output register fills and the input stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && n_accepted >= HoldAtFirst) ||
                   (holds_done == 1 && n_accepted >= HoldAtNext)) begin
        hold_left  <= HoldCycles;
        holds_done <= holds_done + 1;
      end
    end
  end

  // Receiver: check each status word against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < MaxReports)
            $display("%0t: unexpected status word %h", $realtime, m_tdata);
        end else if (m_tdata[2:0] != status_q[0].status ||
                     m_tdata[4:3] != status_q[0].axis ||
                     m_tdata[20:5] != status_q[0].angle) begin
          n_errors <= n_errors + 1;
          if (n_errors < MaxReports)
            $display("%0t: mismatch: status %0d axis %0d angle %0d, got %0d %0d %0d",
                     $realtime, status_q[0].status, status_q[0].axis, status_q[0].angle,
                     m_tdata[2:0], m_tdata[4:3], m_tdata[20:5]);
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end

      if (rx_mode_left == 0) begin
        rx_calm      <= ($urandom_range(0, 2) == 0);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end

      if (rx_wait != 0) begin
        rx_wait  <= rx_wait - 1;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_wait <= pick_gap();
      end
    end
  end

  // Watchdog: abort when no word moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("motion_command_parser_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    add_directed("");
    add_directed("GO X 36000");
    add_directed("go z0");
    add_directed("Go y 36001");
    add_directed("GO");
    add_directed("GO q 12");
    add_directed("GO Y");
    add_directed("GOX12A5");
    add_directed("GGO  z 00359");
    add_directed("GO X 99999 7");
    add_directed("IM ON");
    add_directed("iim   on");
    add_directed("IM OX");
    add_directed("IM X IM ON");
    add_directed("FINISHED");
    add_directed("ffinishe");
    add_directed("xfinishedx");
    add_directed("IM ON GO X 5");
    add_directed("GO A GO X 1");
    add_directed("finished GO");
    add_directed("IM ON finished");
    put_ch(8'h00);
    add_directed("GO X 1");
    put_ch("G");
    put_ch(8'hCF);
    put_ch(8'hFF);
    add_directed("O finished");
    put_ch(8'hE7);
    put_ch(8'h80);
    add_directed("");

    while (n_queued < RandomItems) add_random_command();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || s_tvalid || status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0 && status_q.size() == 0) begin
      $display("motion_command_parser_unit_tb: PASS");
    end else begin
      if (status_q.size() != 0) $display("%0d status words never arrived", status_q.size());
      $display("motion_command_parser_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mcp_pkg.sv
rtl/core/mcp_go_track.sv
rtl/core/motion_command_parser_unit.sv
tb/sv/motion_command_parser_unit_tb.sv
